[rtl/rblc_pkg.sv]
package rblc_pkg;
   localparam int CacheEntries = 64;
   localparam int MaxSpan      = 64;
   localparam int SlotW        = $clog2(CacheEntries);
   localparam int CountW       = $clog2(CacheEntries + 1);
   localparam int SpanW        = $clog2(MaxSpan + 1);

   typedef enum logic [0:0] {
      REQ_LOOKUP = 1'b0,
      REQ_CLEAR  = 1'b1
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_MIN_MZ     = 1'b0,
      CSR_BLOCK_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] low_mz;
      logic [15:0] high_mz;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] block_index;
      logic        was_hit;
      logic        evicted_valid;
      logic [15:0] evicted_index;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic        truncated;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [15:0] data;
   } csr_payload_type;
endpackage

[rtl/rblc_req_if.sv]
interface rblc_req_if;
   import rblc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/rblc_rsp_if.sv]
interface rblc_rsp_if;
   import rblc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/rblc_csr_if.sv]
interface rblc_csr_if;
   import rblc_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/range_block_lru_cache_tracker.sv]
// Channel | Direction | Payload
// req     | in        | req_type, low_mz, high_mz
// rsp     | out       | block_index, was_hit, evicted_*, hit/miss totals, truncated, last
// csr     | in        | index (0 min_mz, 1 block size), data
// A lookup is accepted, then two serial restoring divides map low and high m/z to blocks, then setup.
// Per block: a search over the resident slots (registered read, then compare), then compaction
// of the later slots on a hit or on a miss in a full store, then an append and an output state;
// a miss in a full store is the worst case.
// A clear empties the store. Synchronous reset empties the store at once.
// A stalled rsp holds the sequencer in its output state; req is taken only when idle.
module range_block_lru_cache_tracker (
   input logic clock,
   input logic reset,
   rblc_req_if.sink   req,
   rblc_rsp_if.source rsp,
   rblc_csr_if.sink   csr
);
   import rblc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIVLO, S_DIVHI, S_SETUP, S_SEARCH, S_CMP, S_SHIFT, S_MOVE, S_APPEND, S_OUT
   } state_type;

   state_type           state_ff;
   logic [15:0]         min_ff, bsize_ff;
   logic [15:0]         tags_ff [CacheEntries];
   logic [15:0]         mem_rd_ff;
   logic [CountW-1:0]   count_ff;
   logic [31:0]         hits_ff, misses_ff;
   logic [15:0]         lo_mz_ff, hi_mz_ff;
   logic [15:0]         quo_ff, rem_ff, lo_blk_ff;
   logic [4:0]          bit_ff;
   logic [15:0]         tag_ff;
   logic [SpanW-1:0]    left_ff;
   logic                trunc_ff;
   logic [CountW-1:0]   pos_ff;
   logic                hit_ff, ev_ff;
   logic [15:0]         ev_tag_ff;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff;

   logic [15:0] bs_eff, div_src, rem_sh, rem_in, quo_in;
   logic [16:0] rem_try;
   logic [16:0] span_w;
   logic [SlotW-1:0] mem_raddr, mem_waddr;
   logic        mem_we;
   logic [15:0] mem_wdata;

   assign bs_eff  = (bsize_ff == 16'd0) ? 16'd1 : bsize_ff;
   assign div_src = (state_ff == S_DIVLO) ? lo_mz_ff : hi_mz_ff;
   assign rem_sh  = {rem_ff[14:0], div_src[bit_ff[3:0]]};
   assign rem_try = {rem_ff[15], rem_sh} - {1'b0, bs_eff};
   always_comb begin
      if (!rem_try[16]) begin
         rem_in = rem_try[15:0];
         quo_in = {quo_ff[14:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         quo_in = {quo_ff[14:0], 1'b0};
      end
   end
   assign span_w = {1'b0, quo_ff} - {1'b0, lo_blk_ff};

   assign mem_raddr = (state_ff == S_SHIFT) ? SlotW'(pos_ff + 1'b1) : pos_ff[SlotW-1:0];
   assign mem_we    = (state_ff == S_MOVE) || (state_ff == S_APPEND);
   assign mem_waddr = (state_ff == S_APPEND) ? count_ff[SlotW-1:0] : pos_ff[SlotW-1:0];
   assign mem_wdata = (state_ff == S_APPEND) ? tag_ff : mem_rd_ff;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) tags_ff[mem_waddr] <= mem_wdata;
      mem_rd_ff <= tags_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         min_ff <= '0; bsize_ff <= 16'd1;
         count_ff <= '0; hits_ff <= '0; misses_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.payload.index)
               CSR_MIN_MZ:     min_ff <= csr.payload.data;
               CSR_BLOCK_SIZE: bsize_ff <= csr.payload.data;
               default: ;
            endcase
         end
         if (rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req.valid) begin
               if (req.payload.req_type == REQ_CLEAR) begin
                  count_ff <= '0;
               end else begin
                  lo_mz_ff <= (req.payload.low_mz < min_ff) ? 16'd0
                              : req.payload.low_mz - min_ff;
                  hi_mz_ff <= (req.payload.high_mz < min_ff) ? 16'd0
                              : req.payload.high_mz - min_ff;
                  rem_ff <= '0; quo_ff <= '0; bit_ff <= 5'd15;
                  state_ff <= S_DIVLO;
               end
            end
            S_DIVLO, S_DIVHI: begin
               if (bit_ff == 5'd0 && state_ff == S_DIVLO) begin
                  lo_blk_ff <= quo_in; rem_ff <= '0; quo_ff <= '0; bit_ff <= 5'd15;
                  state_ff <= S_DIVHI;
               end else begin
                  rem_ff <= rem_in; quo_ff <= quo_in; bit_ff <= bit_ff - 5'd1;
                  if (bit_ff == 5'd0) state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               if (quo_ff < lo_blk_ff) state_ff <= S_IDLE;
               else begin
                  trunc_ff <= span_w >= 17'(MaxSpan);
                  left_ff <= (span_w >= 17'(MaxSpan)) ? SpanW'(MaxSpan)
                             : SpanW'(span_w + 17'd1);
                  tag_ff <= lo_blk_ff; pos_ff <= '0;
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (pos_ff == count_ff) begin
                  hit_ff <= 1'b0;
                  ev_ff <= (count_ff == CountW'(CacheEntries));
                  if (count_ff == CountW'(CacheEntries)) begin
                     pos_ff <= '0; state_ff <= S_SHIFT;
                  end else state_ff <= S_APPEND;
               end else state_ff <= S_CMP;
            end
            S_CMP: begin
               if (pos_ff == '0) ev_tag_ff <= mem_rd_ff;
               if (mem_rd_ff == tag_ff) begin
                  hit_ff <= 1'b1; ev_ff <= 1'b0;
                  state_ff <= S_SHIFT;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
                  state_ff <= S_SEARCH;
               end
            end
            S_SHIFT: begin
               if (pos_ff + 1'b1 >= count_ff) begin
                  count_ff <= count_ff - 1'b1; state_ff <= S_APPEND;
               end else state_ff <= S_MOVE;
            end
            S_MOVE: begin
               pos_ff <= pos_ff + 1'b1;
               state_ff <= S_SHIFT;
            end
            S_APPEND: begin
               count_ff <= count_ff + 1'b1;
               if (hit_ff) hits_ff <= hits_ff + 32'd1;
               else misses_ff <= misses_ff + 32'd1;
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.block_index <= tag_ff;
               rsp_ff.was_hit <= hit_ff;
               rsp_ff.evicted_valid <= ev_ff;
               rsp_ff.evicted_index <= ev_ff ? ev_tag_ff : 16'd0;
               rsp_ff.hit_total <= hits_ff;
               rsp_ff.miss_total <= misses_ff;
               rsp_ff.truncated <= trunc_ff;
               rsp_ff.last <= (left_ff == SpanW'(1));
               left_ff <= left_ff - 1'b1;
               tag_ff <= tag_ff + 16'd1;
               pos_ff <= '0;
               state_ff <= (left_ff == SpanW'(1)) ? S_IDLE : S_SEARCH;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[tb/sv/range_block_lru_cache_tracker_tb.sv]
module range_block_lru_cache_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rblc_pkg::*;

   localparam int IdleLimit  = 40000;
   localparam int HoldCycles = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rblc_req_if req ();
   rblc_rsp_if rsp ();
   rblc_csr_if csr ();

   range_block_lru_cache_tracker i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #5 clock = ~clock;

   // predictor state
   bit [15:0] lru_tags[$];
   bit [31:0] hit_count;
   bit [31:0] miss_count;
   bit [15:0] cfg_min_mz;
   bit [15:0] cfg_block_size;
   rsp_payload_type block_results[$];

   int errors;
   int n_requests;
   int n_results;
   int n_evictions;
   int n_hits;
   int n_truncated;
   int idle_pct;
   int stall_pct;
   int hold_req;
   int hold_taken;
   int hold_left;
   int quiet_cycles;

   function automatic int unsigned mz_to_block(bit [15:0] mz);
      int unsigned bs;
      bs = (cfg_block_size == 0) ? 1 : cfg_block_size;
      if (mz < cfg_min_mz) return 0;
      return (mz - cfg_min_mz) / bs;
   endfunction

   function automatic void predict_lookup(req_payload_type p);
      int unsigned lo;
      int unsigned hi;
      int unsigned n;
      bit trunc;
      bit [15:0] tag;
      int pos;
      rsp_payload_type r;
      if (p.req_type == REQ_CLEAR) begin
         lru_tags.delete();
         return;
      end
      lo = mz_to_block(p.low_mz);
      hi = mz_to_block(p.high_mz);
      if (hi < lo) return;
      n = hi - lo + 1;
      trunc = 1'b0;
      if (n > MaxSpan) begin
         n = MaxSpan;
         trunc = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         tag = 16'(lo + k);
         pos = -1;
         r = '0;
         foreach (lru_tags[i]) if (pos < 0 && lru_tags[i] == tag) pos = i;
         if (pos >= 0) begin
            lru_tags.delete(pos);
            hit_count++;
            r.was_hit = 1'b1;
         end else begin
            if (lru_tags.size() >= CacheEntries) begin
               r.evicted_valid = 1'b1;
               r.evicted_index = lru_tags.pop_front();
            end
            miss_count++;
         end
         lru_tags = {lru_tags, tag};
         r.block_index = tag;
         r.hit_total   = hit_count;
         r.miss_total  = miss_count;
         r.truncated   = trunc;
         r.last        = (k + 1 == n);
         block_results = {block_results, r};
      end
   endfunction

   // valid stays high between back-to-back requests unless idle_pct randomly drops it
   task automatic send_request(req_kind_type kind, bit [15:0] lo, bit [15:0] hi);
      req_payload_type p;
      p.req_type = kind;
      p.low_mz   = lo;
      p.high_mz  = hi;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req.valid   <= 1'b1;
      req.payload <= p;
      do @(posedge clock); while (!(req.valid && req.ready));
      n_requests++;
      predict_lookup(p);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (block_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [15:0] data);
      csr.valid         <= 1'b1;
      csr.payload.index <= idx;
      csr.payload.data  <= data;
      do @(posedge clock); while (!(csr.valid && csr.ready));
      if (idx == CSR_MIN_MZ) cfg_min_mz = data;
      else cfg_block_size = data;
   endtask

   task automatic set_config(bit [15:0] min_mz, bit [15:0] blk_size);
      wait_drained();
      write_csr(CSR_MIN_MZ, min_mz);
      write_csr(CSR_BLOCK_SIZE, blk_size);
      csr.valid <= 1'b0;
   endtask

   function automatic bit [15:0] sat16(int unsigned v);
      return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic test_directed();
      set_config(16'd0, 16'd1);
      send_request(REQ_LOOKUP, 16'd0, 16'd0);
      send_request(REQ_LOOKUP, 16'd0, 16'd0);
      send_request(REQ_LOOKUP, 16'hFFFF, 16'hFFFF);
      send_request(REQ_LOOKUP, 16'd20, 16'd10);
      send_request(REQ_LOOKUP, 16'd0, 16'hFFFF);
      send_request(REQ_LOOKUP, 16'd64, 16'd70);
      send_request(REQ_LOOKUP, 16'd3, 16'd5);
      send_request(REQ_CLEAR, 16'hFFFF, 16'h0000);
      send_request(REQ_LOOKUP, 16'd3, 16'd5);
      set_config(16'd1000, 16'd10);
      send_request(REQ_LOOKUP, 16'd5, 16'd1009);
      send_request(REQ_LOOKUP, 16'd999, 16'd1050);
      send_request(REQ_LOOKUP, 16'd1100, 16'd1000);
      set_config(16'hFFFF, 16'hFFFF);
      send_request(REQ_LOOKUP, 16'd0, 16'hFFFF);
      send_request(REQ_LOOKUP, 16'hFFFE, 16'hFFFF);
      set_config(16'd0, 16'd0);
      send_request(REQ_LOOKUP, 16'd100, 16'd103);
      set_config(16'd0, 16'hFFFF);
      send_request(REQ_LOOKUP, 16'd0, 16'hFFFF);
      send_request(REQ_CLEAR, 16'd0, 16'd0);
   endtask

   task automatic test_random(int n, bit [15:0] min_mz, bit [15:0] blk_size);
      int unsigned bs;
      int unsigned lo;
      int unsigned window;
      int roll;
      set_config(min_mz, blk_size);
      bs = (blk_size == 0) ? 1 : blk_size;
      window = min_mz + $urandom_range(0, 2000) * bs;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            send_request(REQ_CLEAR, 16'($urandom), 16'($urandom));
         end else if (roll < 9) begin
            send_request(REQ_LOOKUP, 16'($urandom), 16'($urandom));
         end else if (roll < 12) begin
            lo = $urandom_range(0, 16'hFFFF);
            send_request(REQ_LOOKUP, sat16(lo), sat16(lo + (64 + $urandom_range(30)) * bs));
         end else if (roll < 30) begin
            lo = $urandom_range(0, 16'hFFFF);
            send_request(REQ_LOOKUP, sat16(lo), sat16(lo + $urandom_range(0, 3) * bs));
         end else begin
            lo = window + $urandom_range(0, 90) * bs + $urandom_range(0, bs - 1);
            send_request(REQ_LOOKUP, sat16(lo), sat16(lo + $urandom_range(0, 5) * bs));
         end
      end
   endtask

   task automatic test_backpressure();
      set_config(16'd50, 16'd3);
      idle_pct  = 0;
      stall_pct = 0;
      hold_req  = hold_req + 1;
      for (int i = 0; i < 20; i++)
         send_request(REQ_LOOKUP, 16'(50 + 6 * i), 16'(50 + 6 * i + 8));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         hold_left  <= 0;
         hold_taken <= hold_req;
      end else if (hold_req != hold_taken) begin
         hold_taken <= hold_req;
         hold_left  <= HoldCycles;
         rsp.ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type exp_r;
      rsp_payload_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.payload;
         n_results++;
         if (block_results.size() == 0) begin
            $error("unexpected result block_index=%0d", got.block_index);
            errors++;
         end else begin
            exp_r = block_results.pop_front();
            if (exp_r.was_hit) n_hits++;
            if (exp_r.evicted_valid) n_evictions++;
            if (exp_r.truncated) n_truncated++;
            if (got.block_index !== exp_r.block_index) begin
               $error("block_index exp %0d got %0d", exp_r.block_index, got.block_index);
               errors++;
            end
            if (got.was_hit !== exp_r.was_hit) begin
               $error("was_hit exp %0d got %0d", exp_r.was_hit, got.was_hit);
               errors++;
            end
            if (got.evicted_valid !== exp_r.evicted_valid) begin
               $error("evicted_valid exp %0d got %0d", exp_r.evicted_valid, got.evicted_valid);
               errors++;
            end
            if (got.evicted_index !== exp_r.evicted_index) begin
               $error("evicted_index exp %0d got %0d", exp_r.evicted_index, got.evicted_index);
               errors++;
            end
            if (got.hit_total !== exp_r.hit_total) begin
               $error("hit_total exp %0d got %0d", exp_r.hit_total, got.hit_total);
               errors++;
            end
            if (got.miss_total !== exp_r.miss_total) begin
               $error("miss_total exp %0d got %0d", exp_r.miss_total, got.miss_total);
               errors++;
            end
            if (got.truncated !== exp_r.truncated) begin
               $error("truncated exp %0d got %0d", exp_r.truncated, got.truncated);
               errors++;
            end
            if (got.last !== exp_r.last) begin
               $error("last exp %0d got %0d", exp_r.last, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("range_block_lru_cache_tracker_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req.valid      = 1'b0;
      req.payload    = '0;
      csr.valid      = 1'b0;
      csr.payload    = '0;
      cfg_min_mz     = 16'd0;
      cfg_block_size = 16'd1;
      idle_pct       = 0;
      stall_pct      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(90, 16'd0, 16'd1);
      idle_pct = 51;
      test_random(90, 16'd200, 16'd7);
      idle_pct  = 0;
      stall_pct = 51;
      test_random(90, 16'($urandom), 16'($urandom_range(1, 40)));
      idle_pct  = 11;
      stall_pct = 11;
      test_random(90, 16'd0, 16'd0);
      idle_pct  = 0;
      stall_pct = 0;
      test_random(60, 16'hFFFF, 16'hFFFF);
      test_backpressure();

      wait_drained();
      if (block_results.size() != 0)
         $error("%0d results never arrived", block_results.size());
      $display("covered %0d requests, %0d block results (%0d hits, %0d evictions, %0d truncated)",
               n_requests, n_results, n_hits, n_evictions, n_truncated);
      $display("six configurations incl. zero and full-scale block size, idle/stall mixes");
      if (errors == 0 && block_results.size() == 0)
         $display("range_block_lru_cache_tracker_tb: clean");
      else
         $display("range_block_lru_cache_tracker_tb: errors");
      $finish;
   end
endmodule
